/* sv/cgbd_pkg.sv */
// Shared constants and types for the complement-graph hop distance core.
`timescale 1ns / 1ps

package cgbd_pkg;

    // Widths fixed by the item and register layout.
    localparam int VERTEX_W = 6;
    localparam int COUNT_W  = 7;
    localparam int DIST_W   = 7;
    localparam int LEVEL_W  = 6;

    // Default size of the vertex set.
    localparam int MAX_VERTICES_DEF = 64;

    // Reset value of the vertex count register.
    localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd64;

    // Distance codes: unreachable reads as minus one, long paths saturate.
    localparam logic signed [DIST_W-1:0] DIST_NONE = -7'sd1;
    localparam logic signed [DIST_W-1:0] DIST_SAME = 7'sd0;
    localparam logic [LEVEL_W-1:0]       LEVEL_MAX = 6'd63;

    // Command codes of an input item.
    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Request from the sequencer to the matrix store.
    typedef struct packed {
        logic rd;
        logic wr;
    } mem_cmd_t;

endpackage

/* sv/cgbd_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module cgbd_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* sv/cgbd_matrix.sv */
// Missing-edge matrix: one RAM row per vertex, with per-row valid flags for reset.
`timescale 1ns / 1ps

module cgbd_matrix #(
    parameter int MAX_VERTICES = cgbd_pkg::MAX_VERTICES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  cgbd_pkg::mem_cmd_t              cmd,
    input  logic [$clog2(MAX_VERTICES)-1:0] addr,
    input  logic [MAX_VERTICES-1:0]         wdata,
    output logic [MAX_VERTICES-1:0]         row
);

    logic [MAX_VERTICES-1:0] row_valid_reg;
    logic                    rd_valid_reg;
    logic [MAX_VERTICES-1:0] ram_row;

    cgbd_ram #(
        .WIDTH (MAX_VERTICES),
        .DEPTH (MAX_VERTICES)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.wr),
        .waddr (addr),
        .wdata (wdata),
        .re    (cmd.rd),
        .raddr (addr),
        .rdata (ram_row)
    );

    // A row never written since reset reads as all zero (no missing edges).
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.wr)
            begin
                row_valid_reg[addr] <= 1'b1;
            end
            if (cmd.rd)
            begin
                rd_valid_reg <= row_valid_reg[addr];
            end
        end
    end

    assign row = rd_valid_reg ? ram_row : '0;

endmodule

/* sv/complement_graph_bfs_distance_core.sv */
// Top level: sequencer and shared row-combine unit of the complement-graph hop distance core.
`timescale 1ns / 1ps

// Keeps a symmetric matrix of missing edges over up to MAX_VERTICES vertices and answers
// hop-distance queries in the complement graph by breadth-first search. An add item is
// accepted, then does a read-modify-write of each of the two matrix rows, and gives no
// beat on the output. A query with a vertex out of range or equal source and target
// answers without a search. Otherwise each search level scans every vertex in use through the
// single matrix read port, one row a cycle, and folds the rows of frontier vertices into the
// next frontier. The core takes one item at a time; the result register lets the next item
// in while a distance beat still waits. The matrix clears at reset through per-row valid
// flags, so no clearing pass is needed.
module complement_graph_bfs_distance_core #(
    parameter int MAX_VERTICES = cgbd_pkg::MAX_VERTICES_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [cgbd_pkg::COUNT_W-1:0]         vertex_count,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 command,
    input  logic [cgbd_pkg::VERTEX_W-1:0]        vertex_a,
    input  logic [cgbd_pkg::VERTEX_W-1:0]        vertex_b,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [cgbd_pkg::DIST_W-1:0]   distance
);

    localparam int VW   = $clog2(MAX_VERTICES);
    localparam int CW   = $clog2(MAX_VERTICES + 1);
    localparam int CMPW = (CW > cgbd_pkg::COUNT_W) ? CW : cgbd_pkg::COUNT_W;
    localparam logic [MAX_VERTICES-1:0] ONE_BIT = {{(MAX_VERTICES-1){1'b0}}, 1'b1};

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD_RD_A,
        S_ADD_WR_A,
        S_ADD_RD_B,
        S_ADD_WR_B,
        S_SCAN,
        S_DRAIN,
        S_LEVEL,
        S_PUSH
    } state_t;

    state_t                              state_reg, state_next;
    logic [cgbd_pkg::COUNT_W-1:0]        count_reg, count_next;
    logic [VW-1:0]                       a_reg, a_next;
    logic [VW-1:0]                       b_reg, b_next;
    logic [MAX_VERTICES-1:0]             frontier_reg, frontier_next;
    logic [MAX_VERTICES-1:0]             unvisited_reg, unvisited_next;
    logic [MAX_VERTICES-1:0]             reach_reg, reach_next;
    logic [cgbd_pkg::LEVEL_W-1:0]        level_reg, level_next;
    logic [VW-1:0]                       scan_reg, scan_next;
    logic                                pend_valid_reg, pend_valid_next;
    logic [VW-1:0]                       pend_addr_reg, pend_addr_next;
    logic signed [cgbd_pkg::DIST_W-1:0]  result_reg, result_next;
    logic                                out_valid_reg, out_valid_next;
    logic signed [cgbd_pkg::DIST_W-1:0]  distance_reg, distance_next;

    logic [CMPW-1:0]                     n_eff;
    logic [CMPW-1:0]                     a_cmp;
    logic [CMPW-1:0]                     b_cmp;
    logic                                pair_in_range;
    logic [MAX_VERTICES-1:0]             in_use;
    logic [MAX_VERTICES-1:0]             row;
    logic [MAX_VERTICES-1:0]             folded;
    logic [cgbd_pkg::LEVEL_W-1:0]        level_inc;
    logic                                scan_last;

    cgbd_pkg::mem_cmd_t                  mem_cmd;
    logic [VW-1:0]                       mem_addr;
    logic [MAX_VERTICES-1:0]             mem_wdata;

    cgbd_matrix #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_matrix (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (mem_cmd),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .row   (row)
    );

    // Effective vertex count and range check of the incoming pair.
    always_comb
    begin
        if (CMPW'(count_reg) < CMPW'(MAX_VERTICES))
        begin
            n_eff = CMPW'(count_reg);
        end
        else
        begin
            n_eff = CMPW'(MAX_VERTICES);
        end
        a_cmp         = CMPW'(vertex_a);
        b_cmp         = CMPW'(vertex_b);
        pair_in_range = (a_cmp < n_eff) && (b_cmp < n_eff);
    end

    // Mask of the vertices in use.
    always_comb
    begin
        for (int i = 0; i < MAX_VERTICES; i++)
        begin
            in_use[i] = (CMPW'(i) < n_eff);
        end
    end

    // Shared combine unit: unvisited neighbours of the frontier vertex whose row has arrived.
    assign folded    = reach_reg | (unvisited_reg & ~row);
    assign level_inc = (level_reg == cgbd_pkg::LEVEL_MAX) ? level_reg : level_reg + 1'b1;
    assign scan_last = (CMPW'(scan_reg) + CMPW'(1)) == n_eff;

    // Sequencer next-state logic.
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        frontier_next   = frontier_reg;
        unvisited_next  = unvisited_reg;
        reach_next      = reach_reg;
        level_next      = level_reg;
        scan_next       = scan_reg;
        pend_valid_next = 1'b0;
        pend_addr_next  = pend_addr_reg;
        result_next     = result_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        distance_next   = distance_reg;
        mem_cmd         = '0;
        mem_addr        = a_reg;
        mem_wdata       = row | (ONE_BIT << b_reg);

        // Configuration beat.
        if (cfg_valid)
        begin
            count_next = vertex_count;
        end

        // Fold the row read in the previous cycle into the next frontier.
        if ((state_reg == S_SCAN || state_reg == S_DRAIN) && pend_valid_reg
            && frontier_reg[pend_addr_reg])
        begin
            reach_next = folded;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    a_next = a_cmp[VW-1:0];
                    b_next = b_cmp[VW-1:0];
                    if (command == cgbd_pkg::CMD_ADD)
                    begin
                        if (pair_in_range)
                        begin
                            state_next = S_ADD_RD_A;
                        end
                    end
                    else if (!pair_in_range)
                    begin
                        result_next = cgbd_pkg::DIST_NONE;
                        state_next  = S_PUSH;
                    end
                    else if (vertex_a == vertex_b)
                    begin
                        result_next = cgbd_pkg::DIST_SAME;
                        state_next  = S_PUSH;
                    end
                    else
                    begin
                        frontier_next  = ONE_BIT << a_cmp[VW-1:0];
                        unvisited_next = in_use & ~(ONE_BIT << a_cmp[VW-1:0]);
                        reach_next     = '0;
                        level_next     = '0;
                        scan_next      = '0;
                        state_next     = S_SCAN;
                    end
                end
            end

            S_ADD_RD_A:
            begin
                mem_cmd.rd = 1'b1;
                mem_addr   = a_reg;
                state_next = S_ADD_WR_A;
            end

            S_ADD_WR_A:
            begin
                mem_cmd.wr = 1'b1;
                mem_addr   = a_reg;
                mem_wdata  = row | (ONE_BIT << b_reg);
                state_next = S_ADD_RD_B;
            end

            S_ADD_RD_B:
            begin
                mem_cmd.rd = 1'b1;
                mem_addr   = b_reg;
                state_next = S_ADD_WR_B;
            end

            S_ADD_WR_B:
            begin
                mem_cmd.wr = 1'b1;
                mem_addr   = b_reg;
                mem_wdata  = row | (ONE_BIT << a_reg);
                state_next = S_IDLE;
            end

            // One matrix row read a cycle over every vertex in use.
            S_SCAN:
            begin
                mem_cmd.rd      = 1'b1;
                mem_addr        = scan_reg;
                pend_valid_next = 1'b1;
                pend_addr_next  = scan_reg;
                if (scan_last)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end

            S_DRAIN:
            begin
                state_next = S_LEVEL;
            end

            // Level done: stop when nothing new was reached or the target was hit.
            S_LEVEL:
            begin
                if (reach_reg == '0)
                begin
                    result_next = cgbd_pkg::DIST_NONE;
                    state_next  = S_PUSH;
                end
                else if (reach_reg[b_reg])
                begin
                    result_next = {1'b0, level_inc};
                    state_next  = S_PUSH;
                end
                else
                begin
                    level_next     = level_inc;
                    frontier_next  = reach_reg;
                    unvisited_next = unvisited_reg & ~reach_reg;
                    reach_next     = '0;
                    scan_next      = '0;
                    state_next     = S_SCAN;
                end
            end

            S_PUSH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    distance_next  = result_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= cgbd_pkg::COUNT_RESET;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            distance_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            distance_reg   <= distance_next;
        end
    end

    // Working registers of the search.
    always_ff @(posedge clk)
    begin
        a_reg         <= a_next;
        b_reg         <= b_next;
        frontier_reg  <= frontier_next;
        unvisited_reg <= unvisited_next;
        reach_reg     <= reach_next;
        level_reg     <= level_next;
        scan_reg      <= scan_next;
        pend_addr_reg <= pend_addr_next;
        result_reg    <= result_next;
    end

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign distance  = distance_reg;

endmodule
